/* hw/rtl/xrg_pkg.sv */
// Shared types and constants for the xoshiro256** random generator.
// No dependencies; used by xrg_ctrl, xrg_datapath and the top level.
package xrg_pkg;

	localparam logic [63:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;
	localparam logic [63:0] RESET_SEED = 64'd1;

	localparam int unsigned MIX_SHIFT_1 = 30;
	localparam int unsigned MIX_SHIFT_2 = 27;
	localparam int unsigned MIX_SHIFT_3 = 31;
	localparam int unsigned UPD_SHIFT = 17;
	localparam int unsigned UPD_ROT = 45;
	localparam int unsigned SCR_ROT = 7;
	localparam int unsigned FRAC_SHIFT = 11;
	localparam int unsigned FRAC_W = 53;

	localparam logic K_SEL_A = 1'b0;
	localparam logic K_SEL_B = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD_RESET,
		OP_LOAD_CFG,
		OP_XS30,
		OP_MUL_LL,
		OP_MUL_LH,
		OP_MUL_HL,
		OP_XS27,
		OP_XS31_STORE,
		OP_DRAW,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       k_sel;
		logic [1:0] word_idx;
	} cmd_t;

endpackage

/* hw/rtl/xoshiro256ss_random_generator_unit.sv */
// Top level of the xoshiro256** random generator.
// Joins xrg_ctrl and xrg_datapath; uses xrg_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  cfg     | in        | cfg_wr_en            | cfg_wr_data (seed, 64 b)
//  in      | in        | in_valid / in_stall  | draw (1 b)
//  out     | out       | out_valid / out_stall| random_value (64 b), unit_fraction (53 b)
//
// A draw does the state update with s1*5, then rotate and *9 into the output
// register once it is free. A transaction with draw low is taken, no result.
// Seeding runs four mixer rounds; each 64-bit multiply is built from the LL,
// LH and HL partial products on the one shared 32x32 multiplier. After reset
// the block loads seed 1 and mixes before it accepts its first transaction.
// The output register holds while out_stall is high; the finished word waits.
module xoshiro256ss_random_generator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [63:0]                cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       draw,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [63:0]                random_value,
	output logic [xrg_pkg::FRAC_W-1:0] unit_fraction
);

	xrg_pkg::cmd_t cmd;

	xrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.in_valid  (in_valid),
		.draw      (draw),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	xrg_datapath u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.cfg_wr_data   (cfg_wr_data),
		.random_value  (random_value),
		.unit_fraction (unit_fraction)
	);

endmodule

/* hw/rtl/xrg_ctrl.sv */
// Controller for the xoshiro256** generator: sequences the seed mixer,
// the draw update and the output register handshake. Uses xrg_pkg.
module xrg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic          in_valid,
	input  logic          draw,
	output logic          in_stall,
	input  logic          out_stall,
	output logic          out_valid,
	output xrg_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_XS30,
		ST_MUL_LL,
		ST_MUL_LH,
		ST_MUL_HL,
		ST_XS27,
		ST_XS31,
		ST_IDLE,
		ST_FINISH
	} state_t;

	state_t     state_q;
	state_t     state_nxt;
	logic       k_sel_q;
	logic [1:0] round_q;
	logic       out_valid_q;
	logic       in_accept;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op       = xrg_pkg::OP_NONE;
		cmd.k_sel    = k_sel_q;
		cmd.word_idx = round_q;
		state_nxt    = state_q;
		case (state_q)
			ST_LOAD: begin
				cmd.op    = xrg_pkg::OP_LOAD_RESET;
				state_nxt = ST_XS30;
			end
			ST_XS30: begin
				cmd.op    = xrg_pkg::OP_XS30;
				state_nxt = ST_MUL_LL;
			end
			ST_MUL_LL: begin
				cmd.op    = xrg_pkg::OP_MUL_LL;
				state_nxt = ST_MUL_LH;
			end
			ST_MUL_LH: begin
				cmd.op    = xrg_pkg::OP_MUL_LH;
				state_nxt = ST_MUL_HL;
			end
			ST_MUL_HL: begin
				cmd.op    = xrg_pkg::OP_MUL_HL;
				state_nxt = (k_sel_q == xrg_pkg::K_SEL_A) ? ST_XS27 : ST_XS31;
			end
			ST_XS27: begin
				cmd.op    = xrg_pkg::OP_XS27;
				state_nxt = ST_MUL_LL;
			end
			ST_XS31: begin
				cmd.op    = xrg_pkg::OP_XS31_STORE;
				state_nxt = (round_q == 2'd3) ? ST_IDLE : ST_XS30;
			end
			ST_IDLE: begin
				if (in_accept && draw) begin
					cmd.op    = xrg_pkg::OP_DRAW;
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold s1*5 until the output register frees up, then scramble it
				if (out_free) begin
					cmd.op    = xrg_pkg::OP_FINISH;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
		// a seed write restarts the mixer from its first round
		if (cfg_wr_en) begin
			cmd.op    = xrg_pkg::OP_LOAD_CFG;
			state_nxt = ST_XS30;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			k_sel_q     <= xrg_pkg::K_SEL_A;
			round_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				k_sel_q <= xrg_pkg::K_SEL_A;
				round_q <= 2'd0;
			end else begin
				if (state_q == ST_XS30) begin
					k_sel_q <= xrg_pkg::K_SEL_A;
				end
				if (state_q == ST_XS27) begin
					k_sel_q <= xrg_pkg::K_SEL_B;
				end
				if (state_q == ST_XS31) begin
					round_q <= round_q + 2'd1;
				end
			end
			if (cmd.op == xrg_pkg::OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_draw_to_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && draw && !cfg_wr_en) |=> (state_q == ST_FINISH))
		else $error("accepted draw did not move to finish");

	a_cfg_restarts_mix: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> (state_q == ST_XS30 && round_q == 2'd0))
		else $error("seed write did not restart the mixer");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

	a_xs27_uses_a: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_XS27) |-> (k_sel_q == xrg_pkg::K_SEL_A))
		else $error("second multiply selected before first finished");

endmodule

/* hw/rtl/xrg_datapath.sv */
// Datapath for the xoshiro256** generator: state words, mixer register,
// shared 32x32 multiplier, scrambler and output register. Uses xrg_pkg.
module xrg_datapath (
	input  logic                        clk,
	input  xrg_pkg::cmd_t               cmd,
	input  logic [63:0]                 cfg_wr_data,
	output logic [63:0]                 random_value,
	output logic [xrg_pkg::FRAC_W-1:0]  unit_fraction
);

	logic [63:0] s_q [4];
	logic [63:0] m_q;
	logic [63:0] prod_q;
	logic [63:0] t_q;
	logic [63:0] rand_q;

	logic [63:0] k;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] pp;
	logic [31:0] hi_sum;
	logic [63:0] rot_t;
	logic [63:0] xs31;

	assign k     = (cmd.k_sel == xrg_pkg::K_SEL_A) ? xrg_pkg::MIX_MUL_A : xrg_pkg::MIX_MUL_B;
	assign mul_a = (cmd.op == xrg_pkg::OP_MUL_HL) ? m_q[63:32] : m_q[31:0];
	assign mul_b = (cmd.op == xrg_pkg::OP_MUL_LH) ? k[63:32] : k[31:0];
	assign pp    = 64'(mul_a) * 64'(mul_b);
	// cross terms only reach the upper half of the low 64 product bits
	assign hi_sum = prod_q[63:32] + pp[31:0];
	assign rot_t  = (t_q << xrg_pkg::SCR_ROT) | (t_q >> (64 - xrg_pkg::SCR_ROT));
	assign xs31   = m_q ^ (m_q >> xrg_pkg::MIX_SHIFT_3);

	always_ff @(posedge clk) begin
		case (cmd.op)
			xrg_pkg::OP_LOAD_RESET: m_q <= xrg_pkg::RESET_SEED;
			xrg_pkg::OP_LOAD_CFG:   m_q <= cfg_wr_data;
			xrg_pkg::OP_XS30:       m_q <= m_q ^ (m_q >> xrg_pkg::MIX_SHIFT_1);
			xrg_pkg::OP_MUL_LL:     prod_q <= pp;
			xrg_pkg::OP_MUL_LH:     prod_q[63:32] <= hi_sum;
			xrg_pkg::OP_MUL_HL:     m_q <= {hi_sum, prod_q[31:0]};
			xrg_pkg::OP_XS27:       m_q <= m_q ^ (m_q >> xrg_pkg::MIX_SHIFT_2);
			xrg_pkg::OP_XS31_STORE: begin
				m_q <= xs31;
				s_q[cmd.word_idx] <= xs31;
			end
			xrg_pkg::OP_DRAW: begin
				// take s1*5 before the update, then advance all four words
				t_q    <= (s_q[1] << 2) + s_q[1];
				s_q[0] <= s_q[0] ^ s_q[3] ^ s_q[1];
				s_q[1] <= s_q[1] ^ s_q[2] ^ s_q[0];
				s_q[2] <= s_q[2] ^ s_q[0] ^ (s_q[1] << xrg_pkg::UPD_SHIFT);
				s_q[3] <= ((s_q[3] ^ s_q[1]) << xrg_pkg::UPD_ROT)
				        | ((s_q[3] ^ s_q[1]) >> (64 - xrg_pkg::UPD_ROT));
			end
			xrg_pkg::OP_FINISH:     rand_q <= (rot_t << 3) + rot_t;
			default: ;
		endcase
	end

	assign random_value  = rand_q;
	assign unit_fraction = rand_q[63:xrg_pkg::FRAC_SHIFT];

endmodule

/* sim/tb.sv */
// Self-checking bench for xoshiro256ss_random_generator_unit: directed table, then seeded
// random phases, all scored against an in-bench xoshiro256** model.
// Depends on xrg_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module tb;

	localparam int unsigned DIR_N = 24;
	localparam int unsigned RANDOM_DRAWS = 820;
	localparam int unsigned SEED_PAUSE = 8;
	localparam int unsigned RX_HOLD_CYCLES = 400;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SHOWN_FAULTS = 10;

	typedef enum logic {ROW_DRAW, ROW_SEED} row_kind_t;
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        draw;
		logic [63:0] seed;
		logic        known;
		logic [63:0] value;
	} dir_row_t;

	typedef struct packed {
		logic [63:0]                value;
		logic [xrg_pkg::FRAC_W-1:0] frac;
	} draw_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_wr_en = 1'b0;
	logic [63:0]                cfg_wr_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       draw = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [63:0]                random_value;
	logic [xrg_pkg::FRAC_W-1:0] unit_fraction;

	logic [63:0]  xs_state [4];
	draw_result_t pending_draws [$];
	int unsigned  fault_count = 0;
	bit           hold_request = 1'b0;

	// seed zero rows carry their known all-zero output
	dir_row_t dir_rows [DIR_N] = '{
		'{ROW_DRAW, 1'b1, 64'd0, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b0, 64'd0, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b0, 64'd0},
		'{ROW_SEED, 1'b0, 64'd0, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b1, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b1, 64'd0},
		'{ROW_DRAW, 1'b0, 64'd0, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b1, 64'd0},
		'{ROW_SEED, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b0, 64'd0},
		'{ROW_SEED, 1'b0, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b0, 64'd0, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b0, 64'd0},
		'{ROW_SEED, 1'b0, xrg_pkg::RESET_SEED, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b0, 64'd0},
		'{ROW_SEED, 1'b0, 64'h0123_4567_89AB_CDEF, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b0, 64'd0},
		'{ROW_DRAW, 1'b1, 64'd0, 1'b0, 64'd0}
	};

	xoshiro256ss_random_generator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.draw         (draw),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.random_value (random_value),
		.unit_fraction(unit_fraction)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned k);
		return (v << k) | (v >> (64 - k));
	endfunction

	// chained mixer: each round's value becomes the next state word
	task automatic xs_reseed(input logic [63:0] v);
		logic [63:0] m;
		m = v;
		for (int w = 0; w < 4; w++) begin
			m ^= m >> xrg_pkg::MIX_SHIFT_1;
			m = m * xrg_pkg::MIX_MUL_A;
			m ^= m >> xrg_pkg::MIX_SHIFT_2;
			m = m * xrg_pkg::MIX_MUL_B;
			m ^= m >> xrg_pkg::MIX_SHIFT_3;
			xs_state[w] = m;
		end
	endtask

	// scramble from the old state, then advance it
	task automatic xoshiro_draw(output logic [63:0] word);
		logic [63:0] carry;
		word = rotl64(xs_state[1] * 64'd5, xrg_pkg::SCR_ROT) * 64'd9;
		carry = xs_state[1] << xrg_pkg::UPD_SHIFT;
		xs_state[2] ^= xs_state[0];
		xs_state[3] ^= xs_state[1];
		xs_state[1] ^= xs_state[2];
		xs_state[0] ^= xs_state[3];
		xs_state[2] ^= carry;
		xs_state[3] = rotl64(xs_state[3], xrg_pkg::UPD_ROT);
	endtask

	task automatic note_fault(input string what, input draw_result_t want,
			input draw_result_t got);
		fault_count++;
		if (fault_count <= SHOWN_FAULTS)
			$display("%0t %s: exp value=%h frac=%h, got value=%h frac=%h", $realtime, what,
				want.value, want.frac, got.value, got.frac);
	endtask

	// offer one transaction and hold it until taken
	task automatic send_item(input logic d, input logic known, input logic [63:0] value);
		logic [63:0] word;
		draw_result_t res;
		@(negedge clk);
		in_valid <= 1'b1;
		draw <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (d) begin
			xoshiro_draw(word);
			res.value = known ? value : word;
			res.frac = res.value[63:xrg_pkg::FRAC_SHIFT];
			pending_draws.push_back(res);
		end
	endtask

	task automatic idle_input(input int unsigned n);
		@(negedge clk);
		in_valid <= 1'b0;
		draw <= 1'($urandom_range(0, 1));
		if (n > 1)
			repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain_draws();
		idle_input(1);
		while (pending_draws.size() != 0)
			@(negedge clk);
	endtask

	// write only once idle; a draw-low transaction leaves no result to wait for
	task automatic write_seed(input logic [63:0] v);
		drain_draws();
		repeat (SEED_PAUSE) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		xs_reseed(v);
	endtask

	always @(posedge clk) begin : result_check
		draw_result_t want, got;
		if (arst_n && out_valid && !out_stall) begin
			got.value = random_value;
			got.frac = unit_fraction;
			if (pending_draws.size() == 0) begin
				note_fault("result with no pending draw", '0, got);
			end else begin
				want = pending_draws.pop_front();
				if (got.value !== want.value)
					note_fault("random_value mismatch", want, got);
				if (got.frac !== want.frac)
					note_fault("unit_fraction mismatch", want, got);
			end
		end
	end

	initial begin : rx_pattern
		int unsigned cyc, hold_left;
		rx_mode_t mode;
		bit hold_served;
		cyc = 0;
		hold_left = 0;
		mode = RX_OPEN;
		hold_served = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 128 == 0)
				mode = rx_mode_t'($urandom_range(0, 3));
			if (hold_request && !hold_served) begin
				hold_served = 1'b1;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					RX_OPEN: out_stall <= 1'b0;
					RX_COIN: out_stall <= 1'($urandom_range(0, 1));
					RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 85);
					default: out_stall <= ((cyc % 7) < 3);
				endcase
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int unsigned draws_done, phase, phase_len, n, burst_left;
		logic [63:0] seed_val;
		logic d;
		bit no_gaps, paused;
		draws_done = 0;
		phase = 0;
		paused = 1'b0;
		xs_reseed(xrg_pkg::RESET_SEED);
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++) begin
			if (dir_rows[i].kind == ROW_SEED)
				write_seed(dir_rows[i].seed);
			else
				send_item(dir_rows[i].draw, dir_rows[i].known, dir_rows[i].value);
		end

		while (draws_done < RANDOM_DRAWS) begin
			phase++;
			case ($urandom_range(0, 9))
				0: seed_val = '0;
				1: seed_val = '1;
				2: seed_val = xrg_pkg::RESET_SEED;
				default: seed_val = {$urandom, $urandom};
			endcase
			write_seed(seed_val);
			// back up the output side while the input keeps offering
			if (phase == 2)
				hold_request = 1'b1;
			phase_len = $urandom_range(60, 180);
			no_gaps = ($urandom_range(0, 3) == 0);
			n = 0;
			while (n < phase_len && draws_done < RANDOM_DRAWS) begin
				burst_left = $urandom_range(1, 40);
				while (burst_left != 0 && n < phase_len && draws_done < RANDOM_DRAWS) begin
					d = ($urandom_range(0, 7) != 0);
					send_item(d, 1'b0, '0);
					if (d) begin
						n++;
						draws_done++;
					end
					burst_left--;
				end
				if (!no_gaps && $urandom_range(0, 2) != 0)
					idle_input($urandom_range(1, 12));
				// let the pipeline run dry once mid-phase
				if (phase == 3 && !paused && n >= phase_len / 2) begin
					paused = 1'b1;
					drain_draws();
				end
			end
		end

		drain_draws();
		repeat (10) @(posedge clk);
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
